FILE: hdl/rc4_pkg.sv
// rc4_pkg: shared constants, register indexes, datapath op codes and command type
// for the rc4 cipher engine; no dependencies
package rc4_pkg;

    localparam int MAX_KEY_BYTES_DEF = 32;
    localparam int MIN_KEY_BYTES     = 5;
    localparam int PERM_SIZE         = 256;
    localparam int DEFAULT_DISCARD   = 3072;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_LEN_W  = 6;
    localparam int DISC_W     = 16;
    localparam int KEY_SEL_W  = 5;
    localparam int OP_W       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD    = 3'd5;

    localparam logic REQ_INIT  = 1'b0;
    localparam logic REQ_CRYPT = 1'b1;

    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_FILL    = 4'd1;
    localparam logic [OP_W-1:0] OP_KS_RD_N = 4'd2;
    localparam logic [OP_W-1:0] OP_KS_RD_J = 4'd3;
    localparam logic [OP_W-1:0] OP_KS_WR_N = 4'd4;
    localparam logic [OP_W-1:0] OP_KS_WR_J = 4'd5;
    localparam logic [OP_W-1:0] OP_CLR_IJ  = 4'd6;
    localparam logic [OP_W-1:0] OP_G_RD_I  = 4'd7;
    localparam logic [OP_W-1:0] OP_G_RD_J  = 4'd8;
    localparam logic [OP_W-1:0] OP_G_WR_I  = 4'd9;
    localparam logic [OP_W-1:0] OP_G_WR_J  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] n;
        logic              load_in;
        logic              load_out;
    } rc4_cmd_t;

endpackage

FILE: hdl/rc4_stream_cipher_top.sv
// rc4_stream_cipher_top: rc4 engine with keystream drop, top level
// depends on rc4_pkg, rc4_cfg, rc4_ctrl and rc4_dp
//
// channel   signals                              payload
// in        in_valid / in_ready                  req_type, data_in
// out       out_valid / out_ready                data_out
// cfg       cfg_we, cfg_index (write only)       cfg_data
//
// a crypt request runs four memory steps for the swap and keystream read and
// one output step, then returns to idle before the next accept
// an init request refills the table, runs the key schedule, clears i and j and
// runs discard_count generator rounds before the next accept
// after reset a pass loads the identity table, in_ready stays low
// the output register holds a result until taken; the next request is
// accepted meanwhile, and a crypt request stalls in its last step if the
// previous result has not been taken
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [rc4_pkg::BYTE_W-1:0]         data_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]         data_out,
    input  logic                               cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rc4_pkg::*;

    localparam int KIDX_W = $clog2(MAX_KEY_BYTES);

    rc4_cmd_t          cmd;
    logic [KIDX_W-1:0] key_idx;
    logic [KIDX_W-1:0] key_last;
    logic [BYTE_W-1:0] key_byte;
    logic [DISC_W-1:0] discard_count;

    rc4_cfg #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .key_idx       (key_idx),
        .key_byte      (key_byte),
        .key_last      (key_last),
        .discard_count (discard_count)
    );

    rc4_ctrl #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_last      (key_last),
        .discard_count (discard_count),
        .key_idx       (key_idx),
        .cmd           (cmd)
    );

    rc4_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .key_byte (key_byte),
        .data_in  (data_in),
        .data_out (data_out)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous one still in progress");

    a_init_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == REQ_INIT) |=> !$rose(out_valid))
        else $error("init request produced a result");

    a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while engine still busy");
`endif

endmodule

FILE: hdl/rc4_cfg.sv
// rc4_cfg: configuration registers, key length clamp and key byte select
// depends on rc4_pkg
module rc4_cfg #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
    localparam int KIDX_W = $clog2(MAX_KEY_BYTES)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [KIDX_W-1:0]                  key_idx,
    output logic [rc4_pkg::BYTE_W-1:0]         key_byte,
    output logic [KIDX_W-1:0]                  key_last,
    output logic [rc4_pkg::DISC_W-1:0]         discard_count
);
    import rc4_pkg::*;

    logic [KEY_LEN_W-1:0]    key_length_reg;
    logic [CFG_DATA_W-1:0]   key_w0_reg;
    logic [CFG_DATA_W-1:0]   key_w1_reg;
    logic [CFG_DATA_W-1:0]   key_w2_reg;
    logic [CFG_DATA_W-1:0]   key_w3_reg;
    logic [DISC_W-1:0]       discard_reg;
    logic [4*CFG_DATA_W-1:0] key_vec;
    logic [KEY_LEN_W-1:0]    key_len_eff;
    logic [KEY_SEL_W-1:0]    key_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_W'(MIN_KEY_BYTES);
            key_w0_reg     <= '0;
            key_w1_reg     <= '0;
            key_w2_reg     <= '0;
            key_w3_reg     <= '0;
            discard_reg    <= DISC_W'(DEFAULT_DISCARD);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                REG_KEY_0_7:    key_w0_reg     <= cfg_data;
                REG_KEY_8_15:   key_w1_reg     <= cfg_data;
                REG_KEY_16_23:  key_w2_reg     <= cfg_data;
                REG_KEY_24_31:  key_w3_reg     <= cfg_data;
                REG_DISCARD:    discard_reg    <= cfg_data[DISC_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (key_length_reg < KEY_LEN_W'(MIN_KEY_BYTES))
            key_len_eff = KEY_LEN_W'(MIN_KEY_BYTES);
        else if (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES))
            key_len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        else
            key_len_eff = key_length_reg;
    end

    assign key_last      = KIDX_W'(key_len_eff - KEY_LEN_W'(1));
    assign key_vec       = {key_w3_reg, key_w2_reg, key_w1_reg, key_w0_reg};
    assign key_sel       = KEY_SEL_W'(key_idx);
    assign key_byte      = key_vec[key_sel*BYTE_W +: BYTE_W];
    assign discard_count = discard_reg;

endmodule

FILE: hdl/rc4_dp.sv
// rc4_dp: permutation memory, generator indices, swap registers and output byte
// depends on rc4_pkg; driven by the rc4_ctrl command
module rc4_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rc4_pkg::rc4_cmd_t           cmd,
    input  logic [rc4_pkg::BYTE_W-1:0]  key_byte,
    input  logic [rc4_pkg::BYTE_W-1:0]  data_in,
    output logic [rc4_pkg::BYTE_W-1:0]  data_out
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] mem [PERM_SIZE];
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] din_reg;
    logic [BYTE_W-1:0] dout_reg;
    logic [BYTE_W-1:0] raddr;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              we;
    logic [BYTE_W-1:0] ks;

    always_comb
    begin
        i_next  = i_reg;
        j_next  = j_reg;
        si_next = si_reg;
        sj_next = sj_reg;
        t_next  = t_reg;
        raddr   = t_reg;
        waddr   = cmd.n;
        wdata   = rdata_reg;
        we      = 1'b0;
        case (cmd.op)
            OP_FILL:
            begin
                we     = 1'b1;
                wdata  = cmd.n;
                i_next = '0;
                j_next = '0;
            end
            OP_KS_RD_N:
                raddr = cmd.n;
            OP_KS_RD_J:
            begin
                si_next = rdata_reg;
                j_next  = j_reg + rdata_reg + key_byte;
                raddr   = j_next;
            end
            OP_KS_WR_N:
            begin
                sj_next = rdata_reg;
                we      = 1'b1;
            end
            OP_KS_WR_J:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = si_reg;
            end
            OP_CLR_IJ:
            begin
                i_next = '0;
                j_next = '0;
            end
            OP_G_RD_I:
            begin
                i_next = i_reg + BYTE_W'(1);
                raddr  = i_next;
            end
            OP_G_RD_J:
            begin
                si_next = rdata_reg;
                j_next  = j_reg + rdata_reg;
                raddr   = j_next;
            end
            OP_G_WR_I:
            begin
                sj_next = rdata_reg;
                we      = 1'b1;
                waddr   = i_reg;
            end
            OP_G_WR_J:
            begin
                we     = 1'b1;
                waddr  = j_reg;
                wdata  = si_reg;
                t_next = si_reg + sj_reg;
                raddr  = t_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // read of S[t] overlaps the write of S[j], so forward on a match
    assign ks = (t_reg == j_reg) ? si_reg : rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg <= si_next;
        sj_reg <= sj_next;
        t_reg  <= t_next;
        if (cmd.load_in)
            din_reg <= data_in;
        if (cmd.load_out)
            dout_reg <= din_reg ^ ks;
    end

    assign data_out = dout_reg;

endmodule

FILE: hdl/rc4_ctrl.sv
// rc4_ctrl: sequencer for table fill, key schedule, discard and crypt steps
// depends on rc4_pkg; issues rc4_cmd_t to rc4_dp
module rc4_ctrl #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
    localparam int KIDX_W = $clog2(MAX_KEY_BYTES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  logic [KIDX_W-1:0]           key_last,
    input  logic [rc4_pkg::DISC_W-1:0]  discard_count,
    output logic [KIDX_W-1:0]           key_idx,
    output rc4_pkg::rc4_cmd_t           cmd
);
    import rc4_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_KS0   = 4'd2;
    localparam logic [3:0] S_KS1   = 4'd3;
    localparam logic [3:0] S_KS2   = 4'd4;
    localparam logic [3:0] S_KS3   = 4'd5;
    localparam logic [3:0] S_CLRIJ = 4'd6;
    localparam logic [3:0] S_G0    = 4'd7;
    localparam logic [3:0] S_G1    = 4'd8;
    localparam logic [3:0] S_G2    = 4'd9;
    localparam logic [3:0] S_G3    = 4'd10;
    localparam logic [3:0] S_G4    = 4'd11;

    localparam logic [BYTE_W-1:0] N_LAST = BYTE_W'(PERM_SIZE - 1);

    logic [3:0]        state_reg, state_next;
    logic [BYTE_W-1:0] n_reg, n_next;
    logic [KIDX_W-1:0] k_reg, k_next;
    logic [DISC_W-1:0] disc_reg, disc_next;
    logic              init_pend_reg, init_pend_next;
    logic              crypt_reg, crypt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        disc_next      = disc_reg;
        init_pend_next = init_pend_reg;
        crypt_next     = crypt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.n          = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (req_type == REQ_CRYPT)
                    begin
                        crypt_next = 1'b1;
                        state_next = S_G0;
                    end
                    else
                    begin
                        init_pend_next = 1'b1;
                        n_next         = '0;
                        state_next     = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                n_next = n_reg + BYTE_W'(1);
                if (n_reg == N_LAST)
                begin
                    k_next     = '0;
                    state_next = init_pend_reg ? S_KS0 : S_IDLE;
                end
            end
            S_KS0:
            begin
                cmd.op     = OP_KS_RD_N;
                state_next = S_KS1;
            end
            S_KS1:
            begin
                cmd.op     = OP_KS_RD_J;
                state_next = S_KS2;
            end
            S_KS2:
            begin
                cmd.op     = OP_KS_WR_N;
                state_next = S_KS3;
            end
            S_KS3:
            begin
                cmd.op     = OP_KS_WR_J;
                n_next     = n_reg + BYTE_W'(1);
                k_next     = (k_reg == key_last) ? '0 : k_reg + KIDX_W'(1);
                state_next = (n_reg == N_LAST) ? S_CLRIJ : S_KS0;
            end
            S_CLRIJ:
            begin
                cmd.op         = OP_CLR_IJ;
                init_pend_next = 1'b0;
                crypt_next     = 1'b0;
                disc_next      = discard_count;
                state_next     = (discard_count == '0) ? S_IDLE : S_G0;
            end
            S_G0:
            begin
                cmd.op     = OP_G_RD_I;
                state_next = S_G1;
            end
            S_G1:
            begin
                cmd.op     = OP_G_RD_J;
                state_next = S_G2;
            end
            S_G2:
            begin
                cmd.op     = OP_G_WR_I;
                state_next = S_G3;
            end
            S_G3:
            begin
                cmd.op = OP_G_WR_J;
                if (crypt_reg)
                    state_next = S_G4;
                else
                begin
                    disc_next  = disc_reg - DISC_W'(1);
                    state_next = (disc_reg == DISC_W'(1)) ? S_IDLE : S_G0;
                end
            end
            S_G4:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    crypt_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            n_reg         <= '0;
            k_reg         <= '0;
            disc_reg      <= '0;
            init_pend_reg <= 1'b0;
            crypt_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            disc_reg      <= disc_next;
            init_pend_reg <= init_pend_next;
            crypt_reg     <= crypt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign key_idx   = k_reg;

endmodule
